[sv/bdq_pkg.sv]
package bdq_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int COUNT_BITS    = 8;
    localparam int FRAME_BITS    = 12;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES_TO_CHECK = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMG_COLS        = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMG_ROWS        = 2'd2;

    localparam logic [COUNT_BITS-1:0] FRAMES_TO_CHECK_RESET = 8'd5;
    localparam logic [FRAME_BITS-1:0] IMG_COLS_RESET        = 12'd2304;
    localparam logic [FRAME_BITS-1:0] IMG_ROWS_RESET        = 12'd1536;

    // A corner counts as unmoved while it differs by less than this in x and y.
    localparam int NEAR_LIMIT = 3;

    typedef struct packed {
        logic empty;
        logic valid;
    } bdq_class_t;

endpackage

[sv/bdq_front.sv]
module bdq_front
    import bdq_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] box_x,
    input  logic [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0] box_width,
    input  logic [COORD_BITS-1:0] box_height,
    input  logic [FRAME_BITS-1:0] img_cols,
    input  logic [FRAME_BITS-1:0] img_rows,
    output bdq_class_t            box_class,
    output logic [COORD_BITS:0]   center_x,
    output logic [COORD_BITS:0]   center_y
);

    // Wide enough for 100 times a coordinate and 19 times a frame size.
    localparam int PW = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS) + 8;

    logic [PW-1:0] wx;
    logic [PW-1:0] hx;
    logic [PW-1:0] fwx;
    logic [PW-1:0] fhx;
    logic [PW-1:0] w5;
    logic [PW-1:0] w25;
    logic [PW-1:0] w50;
    logic [PW-1:0] h3;
    logic [PW-1:0] h8;
    logic [PW-1:0] h25;
    logic [PW-1:0] h100;
    logic [PW-1:0] fw4;
    logic [PW-1:0] fh19;
    logic          aspect_ok;
    logic          wfrac_ok;
    logic          hfrac_ok;

    // All ratio bounds become integer cross products built from shifts and adds.
    always_comb begin
        wx   = PW'(box_width);
        hx   = PW'(box_height);
        fwx  = PW'(img_cols);
        fhx  = PW'(img_rows);
        w5   = (wx << 2) + wx;
        w25  = (wx << 4) + (wx << 3) + wx;
        w50  = w25 << 1;
        h3   = (hx << 1) + hx;
        h8   = hx << 3;
        h25  = (hx << 4) + (hx << 3) + hx;
        h100 = (hx << 6) + (hx << 5) + (hx << 2);
        fw4  = fwx << 2;
        fh19 = (fhx << 4) + (fhx << 1) + fhx;

        aspect_ok = (w5 > h3) && (w5 < h8);
        wfrac_ok  = (w25 < fw4) && (w50 > fwx);
        hfrac_ok  = (h100 < fh19) && (h25 > fhx);

        box_class.empty = (box_width == '0) || (box_height == '0);
        box_class.valid = aspect_ok && wfrac_ok && hfrac_ok;

        center_x = (COORD_BITS+1)'(box_x) + (COORD_BITS+1)'(box_width >> 1);
        center_y = (COORD_BITS+1)'(box_y) + (COORD_BITS+1)'(box_height >> 1);
    end

endmodule

[sv/bdq_fifo.sv]
module bdq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

[sv/bdq_back.sv]
module bdq_back
    import bdq_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [COUNT_BITS-1:0] frames_to_check,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bdq_class_t            in_class,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic [COORD_BITS:0]   in_cx,
    input  logic [COORD_BITS:0]   in_cy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_detected,
    output logic [COORD_BITS:0]   out_center_x,
    output logic [COORD_BITS:0]   out_center_y
);

    logic [COORD_BITS-1:0] ref_x_reg;
    logic [COORD_BITS-1:0] ref_y_reg;
    logic [COUNT_BITS-1:0] stable_count_reg;
    logic                  held_detected_reg;
    logic [COORD_BITS:0]   held_center_x_reg;
    logic [COORD_BITS:0]   held_center_y_reg;
    logic                  out_valid_reg;

    logic                  pop;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  near;
    logic [COUNT_BITS:0]   count_raw;
    logic                  hit;

    // The held report doubles as the output register; it only changes when a
    // beat is taken, and a beat is only taken once the output slot is free.
    assign in_ready     = !out_valid_reg || out_ready;
    assign pop          = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign out_detected = held_detected_reg;
    assign out_center_x = held_center_x_reg;
    assign out_center_y = held_center_y_reg;

    always_comb begin
        dx   = (in_x > ref_x_reg) ? (in_x - ref_x_reg) : (ref_x_reg - in_x);
        dy   = (in_y > ref_y_reg) ? (in_y - ref_y_reg) : (ref_y_reg - in_y);
        near = (dx < COORD_BITS'(NEAR_LIMIT)) && (dy < COORD_BITS'(NEAR_LIMIT));
        if (!in_class.valid) begin
            count_raw = '0;
        end else if (near) begin
            count_raw = (COUNT_BITS+1)'(stable_count_reg) + (COUNT_BITS+1)'(1);
        end else begin
            count_raw = (COUNT_BITS+1)'(1);
        end
        // An invalid box still compares, so a zero threshold reports detected.
        hit = count_raw >= (COUNT_BITS+1)'(frames_to_check);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg         <= '0;
            ref_y_reg         <= '0;
            stable_count_reg  <= '0;
            held_detected_reg <= 1'b0;
            held_center_x_reg <= '0;
            held_center_y_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
                if (in_class.empty) begin
                    stable_count_reg  <= '0;
                    held_detected_reg <= 1'b0;
                    held_center_x_reg <= '0;
                    held_center_y_reg <= '0;
                end else begin
                    if (in_class.valid && !near) begin
                        ref_x_reg <= in_x;
                        ref_y_reg <= in_y;
                    end
                    if (hit) begin
                        stable_count_reg  <= frames_to_check;
                        held_detected_reg <= 1'b1;
                        held_center_x_reg <= in_cx;
                        held_center_y_reg <= in_cy;
                    end else begin
                        stable_count_reg <= count_raw[COUNT_BITS-1:0];
                        if (!in_class.valid) begin
                            held_detected_reg <= 1'b0;
                            held_center_x_reg <= '0;
                            held_center_y_reg <= '0;
                        end
                    end
                end
            end
        end
    end

    a_center_zero_when_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_detected_reg |-> (held_center_x_reg == '0) && (held_center_y_reg == '0))
        else $error("center reported without a detection");

    a_empty_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && in_class.empty |=> !held_detected_reg && (stable_count_reg == '0))
        else $error("empty box did not clear the report");

    a_new_ref_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !in_class.empty && in_class.valid && !near && (frames_to_check > 8'd1)
        |=> (stable_count_reg == 8'd1) && (ref_x_reg == $past(in_x)))
        else $error("moved box did not restart the count");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(held_center_x_reg))
        else $error("result changed while stalled");

endmodule

[sv/box_detection_qualifier.sv]
// Bounding box qualifier. One beat on the s_ channel carries one frame's box
// (x, y, width, height). Each beat yields exactly one result beat on the m_
// channel: the detected flag and the reported center, debounced over
// frames_to_check stable frames.
// The front classifies the box (empty, shape and size bounds against the
// configured frame size) with constant multiplies in the accept cycle and
// writes it into a two-entry queue. The back pops the queue, updates the
// reference corner and stable count, and holds the report in the output
// register. Each box passes through a queue entry and then the output register
// before m_tvalid rises; one box per cycle is sustained while m_tready stays
// high, limited by the single state update per cycle.
// When the receiver stalls, the output register holds its beat and the queue
// fills; s_tready drops only once both queue entries are occupied.
// Reset (aresetn low, synchronous) empties the queue, clears the reference,
// count and report to zero and restores the register defaults 5, 2304, 1536.
// Registers are written through the cfg_ channel, which is always ready;
// write them only while no box is in flight.
module box_detection_qualifier
    import bdq_pkg::*;
#(
    parameter int COORD_BITS = 12,
    localparam int IN_W   = 4 * COORD_BITS,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 2 * COORD_BITS + 3,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // box_x, box_y, box_width, box_height from bit 0 up
    input  logic [IN_TW-1:0]         s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // detected, center_x, center_y from bit 0 up
    output logic [OUT_TW-1:0]        m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int Q_W    = 2 + 2 * COORD_BITS + 2 * (COORD_BITS + 1);

    logic [COUNT_BITS-1:0] frames_to_check_reg;
    logic [FRAME_BITS-1:0] img_cols_reg;
    logic [FRAME_BITS-1:0] img_rows_reg;

    bdq_class_t            f_class;
    logic [COORD_BITS:0]   f_cx;
    logic [COORD_BITS:0]   f_cy;
    logic [Q_W-1:0]        q_wr_data;
    logic [Q_W-1:0]        q_rd_data;
    logic                  q_rd_valid;
    logic                  q_rd_ready;
    bdq_class_t            b_class;
    logic [COORD_BITS-1:0] b_x;
    logic [COORD_BITS-1:0] b_y;
    logic [COORD_BITS:0]   b_cx;
    logic [COORD_BITS:0]   b_cy;
    logic                  o_detected;
    logic [COORD_BITS:0]   o_cx;
    logic [COORD_BITS:0]   o_cy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_to_check_reg <= FRAMES_TO_CHECK_RESET;
            img_cols_reg        <= IMG_COLS_RESET;
            img_rows_reg        <= IMG_ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAMES_TO_CHECK: begin
                    frames_to_check_reg <= cfg_data[COUNT_BITS-1:0];
                end
                REG_IMG_COLS: begin
                    img_cols_reg <= cfg_data[FRAME_BITS-1:0];
                end
                REG_IMG_ROWS: begin
                    img_rows_reg <= cfg_data[FRAME_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bdq_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .box_x       (s_tdata[COORD_BITS-1:0]),
        .box_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .box_width   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .box_height  (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .img_cols    (img_cols_reg),
        .img_rows    (img_rows_reg),
        .box_class   (f_class),
        .center_x    (f_cx),
        .center_y    (f_cy)
    );

    assign q_wr_data = {f_class, s_tdata[2*COORD_BITS-1:0], f_cy, f_cx};

    bdq_fifo #(
        .WIDTH(Q_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(s_tvalid),
        .wr_ready(s_tready),
        .wr_data (q_wr_data),
        .rd_valid(q_rd_valid),
        .rd_ready(q_rd_ready),
        .rd_data (q_rd_data)
    );

    assign {b_class, b_y, b_x, b_cy, b_cx} = q_rd_data;

    bdq_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .frames_to_check(frames_to_check_reg),
        .in_valid       (q_rd_valid),
        .in_ready       (q_rd_ready),
        .in_class       (b_class),
        .in_x           (b_x),
        .in_y           (b_y),
        .in_cx          (b_cx),
        .in_cy          (b_cy),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_detected   (o_detected),
        .out_center_x   (o_cx),
        .out_center_y   (o_cy)
    );

    assign m_tdata = OUT_TW'({o_cy, o_cx, o_detected});

endmodule

[bench/box_detection_qualifier_tb.sv]
module box_detection_qualifier_tb;
    import bdq_pkg::*;

    localparam int COORD_W    = 12;
    localparam int CENTER_W   = COORD_W + 1;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS = 40;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } box_t;

    typedef struct {
        logic                detected;
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
    } report_t;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_DATA_W-1:0]      s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_DATA_W-1:0]      m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Predictor state and register mirror.
    logic [COUNT_BITS-1:0] need_frames = FRAMES_TO_CHECK_RESET;
    logic [FRAME_BITS-1:0] frame_w     = IMG_COLS_RESET;
    logic [FRAME_BITS-1:0] frame_h     = IMG_ROWS_RESET;
    logic [COORD_W-1:0]    anchor_x    = '0;
    logic [COORD_W-1:0]    anchor_y    = '0;
    logic [COUNT_BITS-1:0] stable_run  = '0;
    report_t               held_report = '{1'b0, '0, '0};

    box_t    pending_boxes[$];
    report_t expected_reports[$];

    int boxes_queued    = 0;
    int boxes_accepted  = 0;
    int reports_seen    = 0;
    int detect_reports  = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int reg_settings    = 0;
    bit beat_taken      = 1'b0;
    int burst_left      = 1;
    int gap_left        = 0;
    int ready_run       = 0;
    int stall_left      = 0;

    box_detection_qualifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit shape_ok(int unsigned w, int unsigned h);
        return (5 * w > 3 * h) && (5 * w < 8 * h) &&
               (25 * w < 4 * frame_w) && (50 * w > frame_w) &&
               (100 * h < 19 * frame_h) && (25 * h > frame_h);
    endfunction

    function automatic int unsigned corner_gap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Updates the debounce state with one box and returns the report it yields.
    function automatic report_t judge_box(box_t b);
        logic [COUNT_BITS:0]  tally;
        logic [CENTER_W-1:0]  cx;
        logic [CENTER_W-1:0]  cy;
        if (b.w == 0 || b.h == 0) begin
            stable_run  = '0;
            held_report = '{1'b0, '0, '0};
        end else begin
            cx = {1'b0, b.x} + {2'b0, b.w[COORD_W-1:1]};
            cy = {1'b0, b.y} + {2'b0, b.h[COORD_W-1:1]};
            if (shape_ok(b.w, b.h)) begin
                if (corner_gap(b.x, anchor_x) < NEAR_LIMIT &&
                    corner_gap(b.y, anchor_y) < NEAR_LIMIT) begin
                    tally = {1'b0, stable_run} + (COUNT_BITS+1)'(1);
                end else begin
                    anchor_x = b.x;
                    anchor_y = b.y;
                    tally    = (COUNT_BITS+1)'(1);
                end
            end else begin
                tally       = '0;
                held_report = '{1'b0, '0, '0};
            end
            // With a zero threshold even a rejected box reports a detection.
            if (tally >= {1'b0, need_frames}) begin
                tally       = {1'b0, need_frames};
                held_report = '{1'b1, cx, cy};
            end
            stable_run = tally[COUNT_BITS-1:0];
        end
        return held_report;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic queue_box(input int x, input int y, input int w, input int h);
        box_t b;
        b.x = x[COORD_W-1:0];
        b.y = y[COORD_W-1:0];
        b.w = w[COORD_W-1:0];
        b.h = h[COORD_W-1:0];
        pending_boxes.insert(pending_boxes.size(), b);
        boxes_queued++;
    endtask

    // Tries to pick a width and height that pass the shape tests for the current frame;
    // random ones when the frame size leaves no room, else the last of 20 tries.
    task automatic pick_shape(output int w, output int h);
        int unsigned wlo, whi, hlo, hhi;
        w = $urandom_range(1, 4095);
        h = $urandom_range(1, 4095);
        if (frame_w == 0 || frame_h == 0)
            return;
        wlo = frame_w / 50 + 1;
        whi = (4 * frame_w - 1) / 25;
        hlo = frame_h / 25 + 1;
        hhi = (19 * frame_h - 1) / 100;
        if (whi > 4095) whi = 4095;
        if (hhi > 4095) hhi = 4095;
        if (wlo > whi || hlo > hhi)
            return;
        for (int tries = 0; tries < 20; tries++) begin
            w = $urandom_range(wlo, whi);
            h = $urandom_range(hlo, hhi);
            if (shape_ok(w, h))
                return;
        end
    endtask

    function automatic int pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(0, 3);
        else if (r < 30)
            return 4095 - $urandom_range(0, 3);
        return $urandom_range(0, 4095);
    endfunction

    // A run of boxes hovering around one corner, with occasional breaks.
    task automatic queue_run(input int bx, input int by, input int len,
                             input int break_pct, input int wide_pct);
        int x, y, w, h, spread;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < break_pct) begin
                if ($urandom_range(0, 1) == 0) begin
                    if ($urandom_range(0, 1) == 0)
                        queue_box($urandom, $urandom, 0, $urandom);
                    else
                        queue_box($urandom, $urandom, $urandom, 0);
                end else begin
                    queue_box(bx, by, $urandom_range(1, 4095), $urandom_range(1, 4095));
                end
            end else begin
                spread = ($urandom_range(0, 99) < wide_pct) ? 3 : 2;
                x = bx + $urandom_range(0, spread);
                y = by + $urandom_range(0, spread);
                if (x > 4095) x = 4095;
                if (y > 4095) y = 4095;
                pick_shape(w, h);
                queue_box(x, y, w, h);
            end
        end
    endtask

    task automatic queue_traffic(input int count);
        int pushed, len, cap;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(0, 99) < 70) begin
                cap = need_frames + 3;
                if (cap > 30) cap = 30;
                len = $urandom_range(1, cap);
                queue_run(pick_base(), pick_base(), len, 6, 10);
                pushed += len;
            end else begin
                if ($urandom_range(0, 3) == 0)
                    queue_box($urandom, $urandom, 0, $urandom);
                else
                    queue_box($urandom, $urandom, $urandom, $urandom);
                pushed++;
            end
        end
    endtask

    task automatic drain();
        while (reports_seen < boxes_queued)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Writes all three registers, plus the unused index which must change nothing.
    task automatic write_regs(input int frames, input int fw, input int fh);
        logic [CFG_IDX_BITS-1:0]  idx [4];
        logic [CFG_DATA_BITS-1:0] val [4];
        idx = '{REG_FRAMES_TO_CHECK, REG_IMG_COLS, REG_IMG_ROWS, REG_UNUSED};
        val = '{frames[CFG_DATA_BITS-1:0], fw[CFG_DATA_BITS-1:0], fh[CFG_DATA_BITS-1:0],
                CFG_DATA_BITS'($urandom)};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        reg_settings++;
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(negedge aclk) begin
        box_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !beat_taken) begin
            // Beat still waiting for s_tready.
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_boxes.size() > 0) begin
            b = pending_boxes.pop_front();
            s_tdata  <= {b.h, b.w, b.y, b.x};
            s_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: alternating ready stretches and stalls, with long clean stretches now and then.
    always @(negedge aclk) begin
        logic ready_next;
        if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            ready_next = 1'b1;
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                ready_run  = 60;
                stall_left = 0;
            end else begin
                ready_run  = $urandom_range(0, 12);
                stall_left = $urandom_range(1, 7);
            end
            ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    // Monitor: register mirror, prediction on accepted boxes, checks on results.
    always @(posedge aclk) begin
        box_t    b;
        report_t want;
        report_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
        beat_taken = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAMES_TO_CHECK: need_frames = cfg_data[COUNT_BITS-1:0];
                    REG_IMG_COLS:        frame_w     = cfg_data[FRAME_BITS-1:0];
                    REG_IMG_ROWS:        frame_h     = cfg_data[FRAME_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                {b.h, b.w, b.y, b.x} = s_tdata;
                expected_reports.insert(expected_reports.size(), judge_box(b));
                boxes_accepted++;
            end
            if (m_tvalid && m_tready) begin
                reports_seen++;
                got.detected = m_tdata[0];
                got.cx       = m_tdata[CENTER_W:1];
                got.cy       = m_tdata[2*CENTER_W:CENTER_W+1];
                if (got.detected) detect_reports++;
                if (expected_reports.size() == 0) begin
                    flag_mismatch("result beat with no box outstanding");
                end else begin
                    want = expected_reports.pop_front();
                    if (got.detected !== want.detected)
                        flag_mismatch($sformatf("detected got %0b want %0b",
                                                got.detected, want.detected));
                    if (got.cx !== want.cx)
                        flag_mismatch($sformatf("center_x got %0d want %0d", got.cx, want.cx));
                    if (got.cy !== want.cy)
                        flag_mismatch($sformatf("center_y got %0d want %0d", got.cy, want.cy));
                end
            end
        end
    end

    initial begin
        int bx, by;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed boxes under the reset defaults (5 frames, 2304 x 1536).
        queue_box(0, 0, 0, 0);
        queue_box(17, 33, 0, 5);
        queue_box(4095, 4095, 5, 0);
        queue_box(4095, 4095, 0, 4095);
        queue_box(0, 0, 4095, 4095);
        queue_box(0, 0, 1, 1);
        queue_box(0, 0, 100, 62);          // aspect just too wide
        queue_box(0, 0, 47, 62);           // smallest box that passes at this frame
        queue_box(2, 2, 100, 100);
        queue_box(1, 0, 368, 291);         // largest box that passes
        queue_box(0, 2, 100, 100);
        queue_box(2, 1, 100, 100);         // reaches the threshold
        queue_box(2, 2, 100, 100);
        queue_box(3, 0, 100, 100);         // moved by 3: new reference
        queue_box(4095, 4095, 368, 291);
        queue_box(4093, 4095, 368, 291);
        queue_box(4095, 4093, 368, 291);
        queue_box(4094, 4094, 368, 291);
        queue_box(4093, 4093, 368, 291);   // detected near the far corner
        queue_box(4093, 4093, 4095, 1);    // rejected shape clears the report
        queue_box(100, 100, 200, 150);
        queue_box(100, 100, 0, 150);       // empty box clears the report
        queue_traffic(300);
        drain();

        write_regs(1, 4095, 4095);
        queue_traffic(200);
        drain();

        // Longest threshold: one long steady run plus some traffic.
        write_regs(255, 2304, 1536);
        queue_run(2000, 1000, 262, 0, 0);
        queue_traffic(40);
        drain();

        // Zero threshold and zero frame size: everything non-empty is rejected yet reported.
        write_regs(0, 0, 0);
        queue_traffic(100);
        drain();

        write_regs(4, 4095, 0);
        queue_traffic(40);
        drain();

        write_regs(2, 1, 4095);
        queue_traffic(40);
        drain();

        // Lowered threshold while the count already sits above it.
        write_regs(10, 2304, 1536);
        bx = $urandom_range(10, 4000);
        by = $urandom_range(10, 4000);
        queue_run(bx, by, 13, 0, 0);
        drain();
        write_regs(2, 2304, 1536);
        queue_run(bx, by, 4, 0, 0);
        drain();

        write_regs($urandom_range(2, 12), $urandom_range(200, 4095), $urandom_range(200, 4095));
        queue_traffic(200);
        drain();

        write_regs($urandom_range(1, 8), $urandom_range(400, 4095), $urandom_range(400, 4095));
        queue_traffic(200);
        drain();

        $display("covered %0d boxes and %0d result beats (%0d reporting a detection)",
                 boxes_accepted, reports_seen, detect_reports);
        $display("over %0d register settings including zero and full-scale values",
                 reg_settings + 1);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, expected_reports.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
sv/bdq_pkg.sv
sv/bdq_front.sv
sv/bdq_fifo.sv
sv/bdq_back.sv
sv/box_detection_qualifier.sv
bench/box_detection_qualifier_tb.sv
